/* src/hjbt_pkg.sv */
package hjbt_pkg;

   // Default sizes of the table.
   localparam int NUM_BUCKETS_DEF      = 1024;
   localparam int SLOTS_PER_BUCKET_DEF = 8;
   localparam int KEY_WIDTH_DEF        = 32;

   // Fixed widths of the item fields and the configuration register.
   localparam int KEY_FIELD_W = 32;
   localparam int COUNT_W     = 4;
   localparam int CSR_W       = 4;

   // Bucket bits: reset value and the largest value the register may select.
   localparam logic [CSR_W-1:0] BUCKET_BITS_RESET = 4'd10;
   localparam int               MAX_BUCKET_BITS   = 10;

   // The match count saturates here.
   localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd15;

   // Operation codes.
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_PROBE  = 1'b1;

   // Result status codes.
   localparam logic STATUS_DONE    = 1'b0;
   localparam logic STATUS_DROPPED = 1'b1;

   // One input item.
   typedef struct packed {
      logic                   operation;
      logic [KEY_FIELD_W-1:0] key;
   } req_type;

   // One result item.
   typedef struct packed {
      logic [COUNT_W-1:0] match_count;
      logic               status;
   } rsp_type;

endpackage

/* src/hjbt_ram.sv */
module hjbt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* src/hjbt_match.sv */
module hjbt_match #(
   parameter int KW = 32
) (
   input  logic                              clock,
   input  logic                              clear,
   input  logic                              valid,
   input  logic [KW-1:0]                     stored_key,
   input  logic [KW-1:0]                     probe_key,
   output logic [hjbt_pkg::COUNT_W-1:0]      count
);

   logic [hjbt_pkg::COUNT_W-1:0] count_ff;
   logic [hjbt_pkg::COUNT_W-1:0] count_in;

   // Shared comparator: one stored key per cycle, counting up to saturation.
   always_comb begin
      count_in = count_ff;
      if (clear) begin
         count_in = '0;
      end else if (valid && (stored_key == probe_key) && (count_ff != hjbt_pkg::COUNT_MAX)) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
   end

   assign count = count_ff;

endmodule

/* src/hjbt_ctrl.sv */
module hjbt_ctrl #(
   parameter int NUM_BUCKETS      = hjbt_pkg::NUM_BUCKETS_DEF,
   parameter int SLOTS_PER_BUCKET = hjbt_pkg::SLOTS_PER_BUCKET_DEF,
   parameter int KEY_WIDTH        = hjbt_pkg::KEY_WIDTH_DEF,
   localparam int SKW   = (KEY_WIDTH < hjbt_pkg::KEY_FIELD_W) ? KEY_WIDTH
                                                               : hjbt_pkg::KEY_FIELD_W,
   localparam int BW    = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1,
   localparam int FW    = $clog2(SLOTS_PER_BUCKET + 1),
   localparam int DEPTH = NUM_BUCKETS * SLOTS_PER_BUCKET,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  hjbt_pkg::req_type             req_data,
   output logic                          rsp_strobe,
   output hjbt_pkg::rsp_type             rsp_data,
   input  logic [hjbt_pkg::CSR_W-1:0]    bucket_bits,
   output logic                          fill_we,
   output logic [BW-1:0]                 fill_waddr,
   output logic [FW-1:0]                 fill_wdata,
   output logic [BW-1:0]                 fill_raddr,
   input  logic [FW-1:0]                 fill_rdata,
   output logic                          key_we,
   output logic [AW-1:0]                 key_waddr,
   output logic [SKW-1:0]                key_wdata,
   output logic [AW-1:0]                 key_raddr,
   input  logic [SKW-1:0]                key_rdata
);

   // Largest usable bucket bits: floor(log2(NUM_BUCKETS)), capped by the register range.
   localparam int LOG_FLOOR = $clog2(NUM_BUCKETS + 1) - 1;
   localparam int LIMIT     = (LOG_FLOOR > hjbt_pkg::MAX_BUCKET_BITS) ? hjbt_pkg::MAX_BUCKET_BITS
                                                                      : LOG_FLOOR;

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_FILL   = 3'd2;
   localparam logic [2:0] ST_INSERT = 3'd3;
   localparam logic [2:0] ST_PROBE  = 3'd4;

   logic [2:0]              state_ff, state_in;
   logic [BW-1:0]           clr_ff, clr_in;
   logic                    op_ff, op_in;
   logic [SKW-1:0]          key_ff, key_in;
   logic [BW-1:0]           bucket_ff, bucket_in;
   logic [FW-1:0]           fill_ff, fill_in;
   logic [AW-1:0]           base_ff, base_in;
   logic [FW-1:0]           slot_ff, slot_in;
   logic                    pend_ff, pend_in;
   logic                    rsp_strobe_ff, rsp_strobe_in;
   hjbt_pkg::rsp_type       rsp_ff, rsp_in;

   logic [hjbt_pkg::CSR_W-1:0] bits_eff;
   logic [SKW-1:0]             req_key;
   logic [hjbt_pkg::KEY_FIELD_W-1:0] req_key_ext;
   logic [BW-1:0]              req_bucket;
   logic                       accept;
   logic                       issue;
   logic                       match_clear;
   logic [hjbt_pkg::COUNT_W-1:0] match_count;

   // Bucket index of the offered item: the low bits of the key under the saturated width.
   always_comb begin
      bits_eff    = (bucket_bits > hjbt_pkg::CSR_W'(LIMIT)) ? hjbt_pkg::CSR_W'(LIMIT)
                                                            : bucket_bits;
      req_key     = req_data.key[SKW-1:0];
      req_key_ext = hjbt_pkg::KEY_FIELD_W'(req_key);
      req_bucket  = req_key_ext[BW-1:0] & ~({BW{1'b1}} << bits_eff);
   end

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign issue  = (state_ff == ST_PROBE) && (slot_ff < fill_ff);

   // The fill count of the offered bucket is fetched while idle.
   assign fill_raddr = req_bucket;
   assign key_raddr  = base_ff + AW'(slot_ff);
   assign key_waddr  = base_ff + AW'(fill_ff);
   assign key_wdata  = key_ff;

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      bucket_in     = bucket_ff;
      fill_in       = fill_ff;
      base_in       = base_ff;
      slot_in       = slot_ff;
      pend_in       = 1'b0;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      match_clear   = 1'b0;
      fill_we       = 1'b0;
      fill_waddr    = bucket_ff;
      fill_wdata    = fill_ff + 1'b1;
      key_we        = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            fill_we    = 1'b1;
            fill_waddr = clr_ff;
            fill_wdata = '0;
            clr_in     = clr_ff + 1'b1;
            if (clr_ff == BW'(NUM_BUCKETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               op_in     = req_data.operation;
               key_in    = req_key;
               bucket_in = req_bucket;
               state_in  = ST_FILL;
            end
         end
         ST_FILL: begin
            fill_in     = fill_rdata;
            base_in     = AW'(AW'(bucket_ff) * AW'(SLOTS_PER_BUCKET));
            slot_in     = '0;
            match_clear = 1'b1;
            state_in    = (op_ff == hjbt_pkg::OP_PROBE) ? ST_PROBE : ST_INSERT;
         end
         ST_INSERT: begin
            rsp_strobe_in      = 1'b1;
            rsp_in.match_count = '0;
            if (fill_ff >= FW'(SLOTS_PER_BUCKET)) begin
               rsp_in.status = hjbt_pkg::STATUS_DROPPED;
            end else begin
               rsp_in.status = hjbt_pkg::STATUS_DONE;
               key_we        = 1'b1;
               fill_we       = 1'b1;
            end
            state_in = ST_IDLE;
         end
         ST_PROBE: begin
            // One slot read issued per cycle; its key is compared in the next cycle.
            if (issue) begin
               slot_in = slot_ff + 1'b1;
               pend_in = 1'b1;
            end else if (!pend_ff) begin
               rsp_strobe_in      = 1'b1;
               rsp_in.match_count = match_count;
               rsp_in.status      = hjbt_pkg::STATUS_DONE;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         pend_ff       <= pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      key_ff    <= key_in;
      bucket_ff <= bucket_in;
      fill_ff   <= fill_in;
      base_ff   <= base_in;
      slot_ff   <= slot_in;
      rsp_ff    <= rsp_in;
   end

   hjbt_match #(
      .KW(SKW)
   ) u_match (
      .clock      (clock),
      .clear      (match_clear),
      .valid      (pend_ff),
      .stored_key (key_rdata),
      .probe_key  (key_ff),
      .count      (match_count)
   );

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // A result only follows the insert step or the end of a probe.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> ($past(state_ff) == ST_INSERT || $past(state_ff) == ST_PROBE))
      else $error("result strobe without a finishing step");

   // A key is only ever written into a bucket that still has room.
   a_key_write: assert property (@(posedge clock) disable iff (reset)
      key_we |-> (state_ff == ST_INSERT && fill_ff < FW'(SLOTS_PER_BUCKET)))
      else $error("key written into a full bucket");

   // The probe never reads past the bucket's fill.
   a_probe_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PROBE) |-> (slot_ff <= fill_ff))
      else $error("probe slot beyond bucket fill");

   // An accepted item always moves on to fetch its fill count.
   a_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_FILL))
      else $error("accepted item did not start");

endmodule

/* src/hash_join_build_probe_table_top.sv */
// Hash join table engine. Each item on req_data either inserts its key into the bucket chosen by
// the key's low bucket_bits bits (saturated to the table size), or drops it when that bucket is
// full, or probes that bucket and counts the stored keys equal to it. An item is taken when
// start is high and busy is low, and exactly one result follows on rsp_data, marked by
// rsp_strobe for a single cycle; it cannot be held off, so it must be captured when it appears.
// An insert passes through the fill fetch and the insert step before its result is registered;
// a probe fetches the fill count, then one comparator reads the key memory one slot per cycle
// and the result is registered once the last comparison has settled. busy stays high until the
// cycle in which the result appears. After reset the block clears the fill counts of all buckets
// and holds busy high meanwhile; csr_we writes of bucket_bits are taken at any time.
module hash_join_build_probe_table_top #(
   parameter int NUM_BUCKETS      = hjbt_pkg::NUM_BUCKETS_DEF,
   parameter int SLOTS_PER_BUCKET = hjbt_pkg::SLOTS_PER_BUCKET_DEF,
   parameter int KEY_WIDTH        = hjbt_pkg::KEY_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  hjbt_pkg::req_type             req_data,
   output logic                          rsp_strobe,
   output hjbt_pkg::rsp_type             rsp_data,
   input  logic                          csr_we,
   input  logic [hjbt_pkg::CSR_W-1:0]    csr_wdata
);

   localparam int SKW   = (KEY_WIDTH < hjbt_pkg::KEY_FIELD_W) ? KEY_WIDTH
                                                               : hjbt_pkg::KEY_FIELD_W;
   localparam int BW    = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
   localparam int FW    = $clog2(SLOTS_PER_BUCKET + 1);
   localparam int DEPTH = NUM_BUCKETS * SLOTS_PER_BUCKET;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [hjbt_pkg::CSR_W-1:0] bucket_bits_ff;

   logic           fill_we;
   logic [BW-1:0]  fill_waddr;
   logic [FW-1:0]  fill_wdata;
   logic [BW-1:0]  fill_raddr;
   logic [FW-1:0]  fill_rdata;
   logic           key_we;
   logic [AW-1:0]  key_waddr;
   logic [SKW-1:0] key_wdata;
   logic [AW-1:0]  key_raddr;
   logic [SKW-1:0] key_rdata;

   // Bucket bits register.
   always_ff @(posedge clock) begin
      if (reset) begin
         bucket_bits_ff <= hjbt_pkg::BUCKET_BITS_RESET;
      end else if (csr_we) begin
         bucket_bits_ff <= csr_wdata;
      end
   end

   hjbt_ctrl #(
      .NUM_BUCKETS      (NUM_BUCKETS),
      .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET),
      .KEY_WIDTH        (KEY_WIDTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data),
      .bucket_bits (bucket_bits_ff),
      .fill_we     (fill_we),
      .fill_waddr  (fill_waddr),
      .fill_wdata  (fill_wdata),
      .fill_raddr  (fill_raddr),
      .fill_rdata  (fill_rdata),
      .key_we      (key_we),
      .key_waddr   (key_waddr),
      .key_wdata   (key_wdata),
      .key_raddr   (key_raddr),
      .key_rdata   (key_rdata)
   );

   // Fill count of each bucket.
   hjbt_ram #(
      .WIDTH (FW),
      .DEPTH (NUM_BUCKETS)
   ) u_fill_ram (
      .clock (clock),
      .we    (fill_we),
      .waddr (fill_waddr),
      .wdata (fill_wdata),
      .raddr (fill_raddr),
      .rdata (fill_rdata)
   );

   // Stored keys, bucket-major.
   hjbt_ram #(
      .WIDTH (SKW),
      .DEPTH (DEPTH)
   ) u_key_ram (
      .clock (clock),
      .we    (key_we),
      .waddr (key_waddr),
      .wdata (key_wdata),
      .raddr (key_raddr),
      .rdata (key_rdata)
   );

endmodule
